// ===== sv/line_projection_smoothing_step_macros.svh =====
// Assertion helpers for the line projection smoothing block.
`ifndef LINE_PROJECTION_SMOOTHING_STEP_MACROS_SVH
`define LINE_PROJECTION_SMOOTHING_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define LPSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LPSS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LPSS_ASSERT(lbl, prop, msg)
`define LPSS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== sv/lpss_pkg.sv =====
package lpss_pkg;
    // multiplier digit size: bits of the second operand taken per cell
    localparam int DIGIT_W = 8;
    // move speed register, Q1.16
    localparam int SPEED_W = 17;
    localparam int SPEED_FRAC = 16;
    localparam logic [SPEED_W-1:0] SPEED_ONE = 17'h10000;
    localparam logic [SPEED_W-1:0] SPEED_RST = 17'h08000;
endpackage

// ===== sv/lpss_in_if.sv =====
interface lpss_in_if #(parameter int COORD_WIDTH = 32);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bz;
    modport source (output valid, px, py, pz, ax, ay, az, bx, by, bz, input ready);
    modport sink (input valid, px, py, pz, ax, ay, az, bx, by, bz, output ready);
endinterface

// ===== sv/lpss_out_if.sv =====
interface lpss_out_if #(parameter int COORD_WIDTH = 32);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] qx;
    logic signed [COORD_WIDTH-1:0] qy;
    logic signed [COORD_WIDTH-1:0] qz;
    logic degenerate;
    modport source (output valid, qx, qy, qz, degenerate, input ready);
    modport sink (input valid, qx, qy, qz, degenerate, output ready);
endinterface

// ===== sv/line_projection_smoothing_step.sv =====
// Boundary vertex smoothing by projection onto the neighbor line.
// Input channel i_in: one beat carries vertex P and neighbors A, B (signed
// fixed point). Output channel o_out: one beat carries the smoothed vertex
// P + s*(Q-P), Q being P projected onto line AB, saturated to the coordinate
// range, plus a degenerate flag set when A equals B (then P passes unchanged).
// Configuration: i_cfg_we writes i_cfg_wdata into the move speed s (Q1.16,
// values above 1.0 act as 1.0); write it only while the block is empty.
// Throughput: one beat per cycle while the receiver does not stall. A beat
// passes the difference stage, M1 = ceil((COORD_WIDTH+1)/8) multiplier digit
// cells, the dot product stage, M1 more digit cells, a difference stage,
// M3 = 3 speed digit cells, the sign stage and one divider cell per quotient bit.
// Reset clears all valid bits and loads s = 0.5; no output beat follows
// until a new input beat enters.
// A stalled receiver freezes the whole cell chain; i_in.ready drops only
// while an output beat waits and o_out.ready is low.
`include "line_projection_smoothing_step_macros.svh"
module line_projection_smoothing_step import lpss_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SPEED_W-1:0] i_cfg_wdata,
    lpss_in_if.sink            i_in,
    lpss_out_if.source         o_out
);
    localparam int W    = COORD_WIDTH;
    localparam int DE   = W + 1;             // d = B-A, e = P-A
    localparam int PW1  = 2 * DE;            // e*d, d*d
    localparam int NUMW = 2 * W + 4;         // dot products
    localparam int PW2  = NUMW + DE;         // d*num, e*den
    localparam int DFW  = PW2 + 1;           // d*num - e*den
    localparam int SOW  = SPEED_W + 1;       // speed as signed operand
    localparam int NW   = DFW + SOW;         // scaled numerator
    localparam int QB   = W + 2;             // quotient magnitude bits
    localparam int XW   = NUMW + SPEED_FRAC + QB; // remainder width
    localparam int SW   = W + 2;             // side: {zero, neg, p}
    localparam int M1   = (DE + DIGIT_W - 1) / DIGIT_W;
    localparam int M3   = (SOW + DIGIT_W - 1) / DIGIT_W;
    localparam int LV   = 2 * M1 + M3 + 4 + QB;
    localparam int RW   = QB + 3;            // final sum width

    logic en;
    logic r_ovld;

    // the chain moves whenever the output register can take a beat
    assign en         = !r_ovld || o_out.ready;
    assign i_in.ready = en;

    // ---- move speed register, clamp to full move ----
    logic [SPEED_W-1:0] r_speed;
    logic [SPEED_W-1:0] s_clamp;
    logic signed [SOW-1:0] s_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RST;
        end else if (i_cfg_we) begin
            r_speed <= i_cfg_wdata;
        end
    end
    assign s_clamp = (r_speed > SPEED_ONE) ? SPEED_ONE : r_speed;
    assign s_op    = $signed({1'b0, s_clamp});

    // ---- valid bits, one per chain position ----
    logic [LV-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[LV-2:0], i_in.valid};
            r_ovld <= r_vld[LV-1];
        end
    end

    // ---- stage 1: differences ----
    logic signed [W-1:0]  p_in [3];
    logic signed [W-1:0]  a_in [3];
    logic signed [W-1:0]  b_in [3];
    logic signed [W-1:0]  r_p  [3];
    logic signed [DE-1:0] r_d  [3];
    logic signed [DE-1:0] r_e  [3];

    assign p_in[0] = i_in.px;
    assign p_in[1] = i_in.py;
    assign p_in[2] = i_in.pz;
    assign a_in[0] = i_in.ax;
    assign a_in[1] = i_in.ay;
    assign a_in[2] = i_in.az;
    assign b_in[0] = i_in.bx;
    assign b_in[1] = i_in.by;
    assign b_in[2] = i_in.bz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_p[c] <= p_in[c];
                r_d[c] <= DE'(b_in[c]) - DE'(a_in[c]);
                r_e[c] <= DE'(p_in[c]) - DE'(a_in[c]);
            end
        end
    end

    // ---- products e*d and d*d ----
    logic signed [PW1-1:0] ed [3];
    logic signed [PW1-1:0] d2 [3];
    for (genvar c = 0; c < 3; c++) begin : g_mul1
        lpss_mul #(.WA(DE), .WB(DE)) u_ed (
            .i_clk(i_clk), .i_en(en), .i_a(r_e[c]), .i_b(r_d[c]), .o_p(ed[c])
        );
        lpss_mul #(.WA(DE), .WB(DE)) u_dd (
            .i_clk(i_clk), .i_en(en), .i_a(r_d[c]), .i_b(r_d[c]), .o_p(d2[c])
        );
    end

    // ---- stage 2: num = e.d, den = d.d ----
    logic signed [NUMW-1:0] r_num;
    logic signed [NUMW-1:0] r_den;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= NUMW'(ed[0]) + NUMW'(ed[1]) + NUMW'(ed[2]);
            r_den <= NUMW'(d2[0]) + NUMW'(d2[1]) + NUMW'(d2[2]);
        end
    end

    // hold d and e until the dot products are ready
    logic [6*DE-1:0] de_in;
    logic [6*DE-1:0] de_out;
    logic signed [DE-1:0] d_dl [3];
    logic signed [DE-1:0] e_dl [3];
    for (genvar c = 0; c < 3; c++) begin : g_depack
        assign de_in[c*DE +: DE]     = r_d[c];
        assign de_in[(3+c)*DE +: DE] = r_e[c];
        assign d_dl[c] = $signed(de_out[c*DE +: DE]);
        assign e_dl[c] = $signed(de_out[(3+c)*DE +: DE]);
    end
    lpss_dly #(.WD(6*DE), .LEN(M1 + 1)) u_de_dly (
        .i_clk(i_clk), .i_en(en), .i_d(de_in), .o_d(de_out)
    );

    // ---- products d*num and e*den, stage 3 difference, times speed ----
    logic signed [PW2-1:0] dn   [3];
    logic signed [PW2-1:0] eden [3];
    logic signed [DFW-1:0] r_df [3];
    logic signed [NW-1:0]  nsc  [3];
    for (genvar c = 0; c < 3; c++) begin : g_mul2
        lpss_mul #(.WA(NUMW), .WB(DE)) u_dn (
            .i_clk(i_clk), .i_en(en), .i_a(r_num), .i_b(d_dl[c]), .o_p(dn[c])
        );
        lpss_mul #(.WA(NUMW), .WB(DE)) u_eden (
            .i_clk(i_clk), .i_en(en), .i_a(r_den), .i_b(e_dl[c]), .o_p(eden[c])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_df[c] <= DFW'(dn[c]) - DFW'(eden[c]);
            end
        end
        lpss_mul #(.WA(DFW), .WB(SOW)) u_sc (
            .i_clk(i_clk), .i_en(en), .i_a(r_df[c]), .i_b(s_op), .o_p(nsc[c])
        );
    end

    // hold den and P until the scaled numerator is ready
    logic [NUMW-1:0] den_dl;
    logic [3*W-1:0]  p_pk;
    logic [3*W-1:0]  p_dl;
    for (genvar c = 0; c < 3; c++) begin : g_ppack
        assign p_pk[c*W +: W] = r_p[c];
    end
    lpss_dly #(.WD(NUMW), .LEN(M1 + M3 + 1)) u_den_dly (
        .i_clk(i_clk), .i_en(en), .i_d(r_den), .o_d(den_dl)
    );
    lpss_dly #(.WD(3*W), .LEN(2*M1 + M3 + 2)) u_p_dly (
        .i_clk(i_clk), .i_en(en), .i_d(p_pk), .o_d(p_dl)
    );

    // ---- stage 4: sign and magnitude, then one divider cell per quotient bit ----
    logic [XW-1:0]   r_mag  [3];
    logic [NUMW-1:0] r_den4;
    logic [SW-1:0]   r_side [3];
    logic            zero_den;

    assign zero_den = (den_dl == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den4 <= den_dl;
            for (int c = 0; c < 3; c++) begin
                r_mag[c]  <= nsc[c][NW-1] ? XW'(-nsc[c]) : XW'(nsc[c]);
                r_side[c] <= {zero_den, nsc[c][NW-1], p_dl[c*W +: W]};
            end
        end
    end

    logic signed [W-1:0] n_q   [3];
    logic                n_deg;

    for (genvar c = 0; c < 3; c++) begin : g_div
        logic [XW-1:0]   rem_w  [QB+1];
        logic [NUMW-1:0] den_w  [QB+1];
        logic [QB-1:0]   quo_w  [QB+1];
        logic [SW-1:0]   side_w [QB+1];

        logic [XW:0]            dd_x;
        logic                   rnd;
        logic [QB:0]            qr;
        logic signed [QB+1:0]   qs;
        logic signed [RW-1:0]   sum;
        logic signed [RW-1:0]   hi_x;
        logic signed [RW-1:0]   lo_x;
        logic signed [W-1:0]    p_f;
        logic signed [W-1:0]    sat;

        assign rem_w[0]  = r_mag[c];
        assign den_w[0]  = r_den4;
        assign quo_w[0]  = '0;
        assign side_w[0] = r_side[c];

        for (genvar j = 0; j < QB; j++) begin : g_cell
            lpss_div_cell #(
                .XW(XW), .DENW(NUMW), .QB(QB), .SH(QB - 1 - j), .SW(SW)
            ) u_cell (
                .i_clk(i_clk), .i_en(en),
                .i_rem(rem_w[j]), .i_den(den_w[j]), .i_quo(quo_w[j]),
                .i_side(side_w[j]),
                .o_rem(rem_w[j+1]), .o_den(den_w[j+1]), .o_quo(quo_w[j+1]),
                .o_side(side_w[j+1])
            );
        end

        // round half away from zero: bump when twice the remainder reaches the divisor
        assign dd_x = (XW+1)'(den_w[QB]) << SPEED_FRAC;
        assign rnd  = ({rem_w[QB], 1'b0} >= dd_x);
        assign qr   = (QB+1)'(quo_w[QB]) + (QB+1)'(rnd);
        assign qs   = side_w[QB][W] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
        assign p_f  = $signed(side_w[QB][W-1:0]);
        assign sum  = RW'(p_f) + RW'(qs);
        assign hi_x = RW'($signed({1'b0, {(W-1){1'b1}}}));
        assign lo_x = RW'($signed({1'b1, {(W-1){1'b0}}}));

        always_comb begin
            if (sum > hi_x) begin
                sat = hi_x[W-1:0];
            end else if (sum < lo_x) begin
                sat = lo_x[W-1:0];
            end else begin
                sat = sum[W-1:0];
            end
        end

        // coincident neighbors: pass P through
        assign n_q[c] = side_w[QB][W+1] ? p_f : sat;

        if (c == 0) begin : g_flag
            assign n_deg = side_w[QB][W+1];
        end
    end

    // ---- output register ----
    logic signed [W-1:0] r_q [3];
    logic                r_deg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_q[c] <= n_q[c];
            end
            r_deg <= n_deg;
        end
    end

    assign o_out.valid      = r_ovld;
    assign o_out.qx         = r_q[0];
    assign o_out.qy         = r_q[1];
    assign o_out.qz         = r_q[2];
    assign o_out.degenerate = r_deg;

    `LPSS_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out.valid && r_vld == '0, "valid after reset")
    `LPSS_ASSERT(a_enter, (i_in.valid && i_in.ready) |=> r_vld[0], "accepted beat lost at entry")
    `LPSS_ASSERT(a_freeze, !i_in.ready |=> $stable(r_vld), "chain moved during stall")
endmodule

// ===== sv/lpss_mul.sv =====
module lpss_mul import lpss_pkg::*; #(
    parameter int WA = 8,
    parameter int WB = 8
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [WA-1:0]       i_a,
    input  logic signed [WB-1:0]       i_b,
    output logic signed [WA+WB-1:0]    o_p
);
    localparam int NS = (WB + DIGIT_W - 1) / DIGIT_W;
    localparam int BW = NS * DIGIT_W;
    localparam int PW = WA + BW;

    logic signed [WA-1:0] r_a   [NS];
    logic signed [BW-1:0] r_b   [NS];
    logic signed [PW-1:0] r_acc [NS];

    for (genvar k = 0; k < NS; k++) begin : g_cell
        logic signed [WA-1:0]        a_in;
        logic signed [BW-1:0]        b_in;
        logic signed [PW-1:0]        acc_in;
        logic [DIGIT_W-1:0]          dig;
        logic signed [DIGIT_W:0]     dsig;
        logic signed [WA+DIGIT_W:0]  term;
        logic signed [PW-1:0]        n_acc;

        if (k == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = BW'(i_b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign acc_in = r_acc[k-1];
        end

        assign dig = b_in[k*DIGIT_W +: DIGIT_W];
        // top digit carries the sign, lower digits are plain magnitudes
        if (k == NS - 1) begin : g_top
            assign dsig = {dig[DIGIT_W-1], dig};
        end else begin : g_low
            assign dsig = {1'b0, dig};
        end
        assign term  = a_in * dsig;
        assign n_acc = acc_in + (PW'(term) <<< (k * DIGIT_W));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]   <= a_in;
                r_b[k]   <= b_in;
                r_acc[k] <= n_acc;
            end
        end
    end

    assign o_p = r_acc[NS-1][WA+WB-1:0];
endmodule

// ===== sv/lpss_div_cell.sv =====
module lpss_div_cell import lpss_pkg::*; #(
    parameter int XW   = 16,
    parameter int DENW = 8,
    parameter int QB   = 8,
    parameter int SH   = 0,
    parameter int SW   = 1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [XW-1:0]   i_rem,
    input  logic [DENW-1:0] i_den,
    input  logic [QB-1:0]   i_quo,
    input  logic [SW-1:0]   i_side,
    output logic [XW-1:0]   o_rem,
    output logic [DENW-1:0] o_den,
    output logic [QB-1:0]   o_quo,
    output logic [SW-1:0]   o_side
);
    logic [XW-1:0] dsh;
    logic          ge;
    logic [XW-1:0] n_rem;
    logic [QB-1:0] n_quo;

    // divisor is den scaled by the speed fraction, aligned to this quotient bit
    assign dsh   = XW'(i_den) << (SH + SPEED_FRAC);
    assign ge    = (i_rem >= dsh);
    assign n_rem = ge ? (i_rem - dsh) : i_rem;
    assign n_quo = i_quo | (QB'(ge) << SH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_den  <= i_den;
            o_quo  <= n_quo;
            o_side <= i_side;
        end
    end
endmodule

// ===== sv/lpss_dly.sv =====
module lpss_dly #(
    parameter int WD  = 1,
    parameter int LEN = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [WD-1:0] i_d,
    output logic [WD-1:0] o_d
);
    logic [WD-1:0] r_tap [LEN];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < LEN; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_d = r_tap[LEN-1];
endmodule

// ===== bench/lpss_projection_checker.sv =====
module lpss_projection_checker import lpss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SPEED_W-1:0] i_cfg_wdata,
    lpss_in_if                 i_in,
    lpss_out_if                i_out,
    output int                 o_fail_count,
    output int                 o_pending
);
    typedef logic signed [255:0] wide_t;
    typedef struct {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic               degenerate;
    } smoothed_t;

    smoothed_t          smoothed_q[$];
    logic [SPEED_W-1:0] speed;

    // Exact-integer projection of P onto line AB, blended by the move speed.
    function automatic smoothed_t smooth_vertex(input logic signed [31:0] pv[3],
                                                input logic signed [31:0] av[3],
                                                input logic signed [31:0] bv[3],
                                                input logic [SPEED_W-1:0] spd);
        smoothed_t res;
        wide_t p[3], d[3], e[3];
        wide_t num, den, dd, n, an, q, r, s, outc[3];
        wide_t hi, lo;
        logic  neg;
        num = 0;
        den = 0;
        hi = 256'sd2147483647;
        lo = -256'sd2147483648;
        for (int c = 0; c < 3; c++) begin
            p[c] = wide_t'(pv[c]);
            d[c] = wide_t'(bv[c]) - wide_t'(av[c]);
            e[c] = p[c] - wide_t'(av[c]);
            num += e[c] * d[c];
            den += d[c] * d[c];
        end
        if (den == 0) begin
            res.qx = pv[0];
            res.qy = pv[1];
            res.qz = pv[2];
            res.degenerate = 1'b1;
            return res;
        end
        // clamp speeds above full move
        s = (spd > SPEED_ONE) ? wide_t'(SPEED_ONE) : wide_t'({1'b0, spd});
        dd = den * 65536;
        for (int c = 0; c < 3; c++) begin
            n = s * (d[c] * num - e[c] * den);
            neg = n < 0;
            an = neg ? -n : n;
            q = an / dd;
            r = an % dd;
            // round half away from zero
            if (2 * r >= dd) q = q + 1;
            outc[c] = p[c] + (neg ? -q : q);
            if (outc[c] > hi) outc[c] = hi;
            if (outc[c] < lo) outc[c] = lo;
        end
        res.qx = outc[0][31:0];
        res.qy = outc[1][31:0];
        res.qz = outc[2][31:0];
        res.degenerate = 1'b0;
        return res;
    endfunction

    assign o_pending = smoothed_q.size();

    always @(posedge i_clk) begin
        logic signed [31:0] pv[3], av[3], bv[3];
        smoothed_t exp_r;
        if (!i_rst_n) begin
            speed <= SPEED_RST;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) speed <= i_cfg_wdata;
            if (i_in.valid && i_in.ready) begin
                pv = '{i_in.px, i_in.py, i_in.pz};
                av = '{i_in.ax, i_in.ay, i_in.az};
                bv = '{i_in.bx, i_in.by, i_in.bz};
                smoothed_q.insert(smoothed_q.size(), smooth_vertex(pv, av, bv, speed));
            end
            if (i_out.valid && i_out.ready) begin
                if (smoothed_q.size() == 0) begin
                    $error("output beat with nothing expected");
                    o_fail_count++;
                end else begin
                    exp_r = smoothed_q.pop_front();
                    if (i_out.qx !== exp_r.qx) begin
                        $error("qx expected %0d got %0d", exp_r.qx, i_out.qx);
                        o_fail_count++;
                    end
                    if (i_out.qy !== exp_r.qy) begin
                        $error("qy expected %0d got %0d", exp_r.qy, i_out.qy);
                        o_fail_count++;
                    end
                    if (i_out.qz !== exp_r.qz) begin
                        $error("qz expected %0d got %0d", exp_r.qz, i_out.qz);
                        o_fail_count++;
                    end
                    if (i_out.degenerate !== exp_r.degenerate) begin
                        $error("degenerate expected %0b got %0b",
                               exp_r.degenerate, i_out.degenerate);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/line_projection_smoothing_step_test.sv =====
module line_projection_smoothing_step_test;
    import lpss_pkg::*;

    // Accept-to-valid depth at COORD_WIDTH = 32, plus margin.
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 255;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [SPEED_W-1:0] i_cfg_wdata = '0;
    int                 fail_count;
    int                 pending;

    // calm: no gaps on either side; want_hold: receiver goes quiet for a long stretch
    logic               calm = 1'b0;
    logic               want_hold = 1'b0;

    lpss_in_if  #(.COORD_WIDTH(32)) in_ch();
    lpss_out_if #(.COORD_WIDTH(32)) out_ch();

    line_projection_smoothing_step #(.COORD_WIDTH(32)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    lpss_projection_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Hard limit: far beyond the slowest legal run.
    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    // Drive the channel idle from time zero.
    initial begin
        in_ch.valid = 1'b0;
        in_ch.px = '0; in_ch.py = '0; in_ch.pz = '0;
        in_ch.ax = '0; in_ch.ay = '0; in_ch.az = '0;
        in_ch.bx = '0; in_ch.by = '0; in_ch.bz = '0;
        out_ch.ready = 1'b0;
    end

    // Receiver: mostly ready, short stalls, a few long ones, one very long hold.
    initial begin
        int  roll;
        int  span;
        bit  held;
        held = 0;
        forever begin
            if (want_hold && !held) begin
                // hold off long enough for the pipeline to fill and back up
                held = 1;
                span = 300;
                repeat (span) begin
                    @(posedge i_clk);
                    out_ch.ready <= 1'b0;
                end
            end else if (calm) begin
                @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) span = 0;
                else if (roll < 95) span = $urandom_range(1, 4);
                else span = $urandom_range(10, 60);
                repeat (span) begin
                    @(posedge i_clk);
                    out_ch.ready <= 1'b0;
                end
                @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one beat and hold it until accepted, then idle for the gap.
    task automatic send_vertex(input logic signed [31:0] p[3],
                               input logic signed [31:0] a[3],
                               input logic signed [31:0] b[3]);
        int roll;
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.px <= p[0]; in_ch.py <= p[1]; in_ch.pz <= p[2];
        in_ch.ax <= a[0]; in_ch.ay <= a[1]; in_ch.az <= a[2];
        in_ch.bx <= b[0]; in_ch.by <= b[1]; in_ch.bz <= b[2];
        do @(posedge i_clk); while (!in_ch.ready);
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) gap = 0;
        else if (roll < 96) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain, let the pipe settle, then load a new move speed.
    task automatic write_speed(input logic [SPEED_W-1:0] value);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] near(input logic signed [31:0] base, input int span);
        return base + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random vertex: mostly local neighborhoods, some wide-range and coincident cases.
    task automatic send_random();
        logic signed [31:0] p[3], a[3], b[3];
        int kind;
        int span;
        kind = $urandom_range(0, 19);
        for (int c = 0; c < 3; c++) begin
            if (kind < 3) begin
                p[c] = $urandom; a[c] = $urandom; b[c] = $urandom;
            end else begin
                span = (kind < 6) ? 16 : (kind < 14 ? 65536 * 4 : 65536 * 4096);
                a[c] = near($signed($urandom_range(0, 1 << 24)) - (1 << 23), 1 << 24);
                b[c] = near(a[c], span);
                p[c] = near(a[c], span);
            end
        end
        if (kind == 19) b = a;
        send_vertex(p, a, b);
    endtask

    task automatic send_directed();
        logic signed [31:0] mx, mn;
        logic signed [31:0] p[3], a[3], b[3];
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        // extremes of every field
        send_vertex('{mx, mx, mx}, '{mn, mn, mn}, '{mx, mx, mx});
        send_vertex('{mn, mn, mn}, '{mx, mx, mx}, '{mn, mn, mn});
        send_vertex('{mx, mn, mx}, '{mn, mx, mn}, '{mn, mn, mx});
        send_vertex('{mn, mx, 0}, '{0, 0, 0}, '{mx, mn, mx});
        send_vertex('{0, 0, 0}, '{mx, mx, mn}, '{mn, mn, mx});
        send_vertex('{-1, -1, -1}, '{0, 0, 0}, '{1, 0, 0});
        send_vertex('{mx, mx, mx}, '{mx, mx, mx}, '{mn, mx, mx});
        // coincident neighbors, including extremes and P on top of them
        send_vertex('{mx, mn, 5}, '{7, 7, 7}, '{7, 7, 7});
        send_vertex('{mn, mx, -3}, '{mn, mn, mn}, '{mn, mn, mn});
        send_vertex('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
        send_vertex('{mx, mx, mx}, '{mx, mx, mx}, '{mx, mx, mx});
        // smallest nonzero line length
        send_vertex('{100, 200, 300}, '{0, 0, 0}, '{0, 0, 1});
        // P already on the line
        send_vertex('{3 << 16, 3 << 16, 3 << 16}, '{0, 0, 0}, '{1 << 16, 1 << 16, 1 << 16});
        // odd distances to force half-way rounding
        send_vertex('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0});
        send_vertex('{-1, 3, 0}, '{0, 0, 0}, '{0, 2, 0});
        send_vertex('{3, 0, 7}, '{0, 0, 0}, '{0, 0, 2});
        // saturation from far off the line
        send_vertex('{mx, 0, 0}, '{mn, mx, 0}, '{mn, mx - 1, 0});
        send_vertex('{mn, 0, 0}, '{mx, mn, 0}, '{mx, mn + 1, 0});
        send_vertex('{0, mx, mx}, '{mn, mn, mn}, '{mn + 1, mn, mn});
        for (int c = 0; c < 3; c++) begin
            a[c] = $urandom; b[c] = $urandom; p[c] = $urandom;
        end
        send_vertex(p, a, b);
    endtask

    initial begin
        logic [SPEED_W-1:0] speeds[6];
        speeds = '{17'd0, SPEED_ONE, 17'h1ffff, 17'd1, 17'd0, SPEED_RST};
        speeds[4] = SPEED_W'($urandom_range(2, 65535));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners at the reset speed, then random beats under each setting
        calm <= 1'b1;
        send_directed();
        calm <= 1'b0;
        send_directed();

        for (int ph = 0; ph < 6; ph++) begin
            write_speed(speeds[ph]);
            if (ph == 1) send_directed();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 2 && i == 20) want_hold <= 1'b1;
                if (ph == 3 && i == 100) begin
                    // pause the sender until everything has come back
                    in_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                calm <= (ph == 4 && i < 80);
                send_random();
            end
        end
        in_ch.valid <= 1'b0;
        calm <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
